// ===== rtl/core/hpt_pkg.sv =====
// Shared types and constants for the homogeneous point transform.
package hpt_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_IDENTITY  = 2'd1,
    CMD_TRANSFORM = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_code_t;

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] Q_ZERO  = 32'h0000_0000;
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Dot products fit 49 signed bits; magnitudes fit 49 unsigned bits.
  localparam int SUM_W     = 49;
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    cmd_code_t          command;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               range_error;
  } res_t;

  // Per-quotient flags that ride alongside the divider.
  typedef struct packed {
    logic num_neg;   // numerator negative
    logic num_nz;    // numerator nonzero
    logic q_neg;     // quotient sign
    logic ovf;       // quotient at least 2^32
  } lane_flags_t;

  typedef struct packed {
    lane_flags_t [2:0] lane;
    logic              den_zero;
  } side_t;

endpackage

// ===== rtl/core/hpt_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
module hpt_divider import hpt_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SUM_W-1:0]   rem_in,
  input  logic [31:0]        low_in,
  input  logic [SUM_W-1:0]   den_in,
  output logic [31:0]        quo
);

  logic [SUM_W-1:0] rem [DIV_STEPS+1];
  logic [31:0]      low [DIV_STEPS+1];
  logic [SUM_W-1:0] den [DIV_STEPS+1];
  logic [31:0]      q   [DIV_STEPS+1];

  assign rem[0] = rem_in;
  assign low[0] = low_in;
  assign den[0] = den_in;
  assign q[0]   = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [SUM_W:0] trial;
    logic           fits;

    assign trial = {rem[k], low[k][31]};
    assign fits  = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fits ? SUM_W'(trial - {1'b0, den[k]}) : trial[SUM_W-1:0];
        low[k+1] <= {low[k][30:0], 1'b0};
        den[k+1] <= den[k];
        q[k+1]   <= {q[k][30:0], fits};
      end
    end
  end

  assign quo = q[DIV_STEPS];

endmodule

// ===== rtl/core/homogeneous_point_transform.sv =====
// Top level: 4x4 Q16.16 matrix store, dot-product pipeline and saturating divide.
//
//   channel  valid      ready      payload  moves
//   command  cmd_valid  cmd_ready  cmd      write entry, load identity, transform
//   result   res_valid  res_ready  res      x/w, y/w, z/w and range_error
//
// One transfer per cycle in each direction while a held result does not stall the pipe.
// A transform passes through multiply, row sums, magnitudes, overflow check,
// 32 divider stages (one quotient bit each) and saturation to the result register.
// Matrix writes and identity loads take effect at their transfer edge and
// yield no result. Reset loads the identity and empties the pipeline.
// The whole pipeline advances together; a stalled result holds every stage.
module homogeneous_point_transform import hpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic en;
  logic take;

  assign en        = !res_valid || res_ready;
  assign cmd_ready = en;
  assign take      = cmd_valid && en;

  // Matrix store, row-major.
  logic [31:0] mat [16];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= ((i % 4) == (i / 4)) ? Q_ONE : Q_ZERO;
      end
    end else if (take) begin
      case (cmd.command)
        CMD_WRITE: begin
          mat[cmd.entry_index] <= cmd.entry_value;
        end
        CMD_IDENTITY: begin
          for (int i = 0; i < 16; i++) begin
            mat[i] <= ((i % 4) == (i / 4)) ? Q_ONE : Q_ZERO;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stage 1: twelve 32x32 products plus the translation column.
  logic signed [31:0] pt [3];
  assign pt[0] = cmd.in_x;
  assign pt[1] = cmd.in_y;
  assign pt[2] = cmd.in_z;

  logic               v1;
  logic signed [63:0] prod [4][3];
  logic signed [31:0] trans [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= take && (cmd.command == CMD_TRANSFORM);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        trans[r] <= mat[4'(r * 4 + 3)];
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(mat[4'(r * 4 + c)]) * pt[c];
        end
      end
    end
  end

  // Stage 2: drop 16 fraction bits (floor) and add each row.
  logic                   v2;
  logic signed [SUM_W-1:0] sum [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum[r] <= $signed({{(SUM_W-32){trans[r][31]}}, trans[r]})
                + $signed({prod[r][0][63], prod[r][0][63:16]})
                + $signed({prod[r][1][63], prod[r][1][63:16]})
                + $signed({prod[r][2][63], prod[r][2][63:16]});
      end
    end
  end

  // Stage 3: split into sign and magnitude; row 3 is w.
  logic             v3;
  logic             sgn [4];
  logic [SUM_W-1:0] mag [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sgn[r] <= sum[r][SUM_W-1];
        mag[r] <= sum[r][SUM_W-1] ? SUM_W'(-sum[r]) : SUM_W'(sum[r]);
      end
    end
  end

  // Stage 4: overflow check (quotient >= 2^32 iff num >> 16 >= den) and
  // divider setup. The dividend is num << 16.
  logic             vld [DIV_STEPS+1];
  side_t            sb  [DIV_STEPS+1];
  logic [SUM_W-1:0] rem0 [3];
  logic [31:0]      low0 [3];
  logic [SUM_W-1:0] den0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den0           <= mag[3];
      sb[0].den_zero <= (mag[3] == '0);
      for (int k = 0; k < 3; k++) begin
        sb[0].lane[k].num_neg <= sgn[k];
        sb[0].lane[k].num_nz  <= (mag[k] != '0);
        sb[0].lane[k].q_neg   <= sgn[k] ^ sgn[3];
        sb[0].lane[k].ovf     <= ({16'b0, mag[k][SUM_W-1:16]} >= mag[3]);
        // Seed with zero on overflow so the divider stays in range.
        rem0[k] <= ({16'b0, mag[k][SUM_W-1:16]} >= mag[3]) ?
                   '0 : {16'b0, mag[k][SUM_W-1:16]};
        low0[k] <= {mag[k][15:0], 16'b0};
      end
    end
  end

  // Divider stages, with valid and flags carried alongside.
  logic [31:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    hpt_divider u_div (
      .clk    (clk),
      .en     (en),
      .rem_in (rem0[k]),
      .low_in (low0[k]),
      .den_in (den0),
      .quo    (quo[k])
    );
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb[s+1] <= sb[s];
      end
    end
  end

  // Output stage: apply sign and saturate.
  side_t       sf;
  logic [31:0] res_val [3];
  logic        lane_err [3];

  assign sf = sb[DIV_STEPS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_err[k] = 1'b0;
      if (sf.den_zero) begin
        lane_err[k] = 1'b1;
        res_val[k]  = !sf.lane[k].num_nz ? Q_ZERO :
                      (sf.lane[k].num_neg ? SAT_NEG : SAT_POS);
      end else if (sf.lane[k].q_neg) begin
        if (sf.lane[k].ovf || quo[k] > SAT_NEG) begin
          lane_err[k] = 1'b1;
          res_val[k]  = SAT_NEG;
        end else begin
          res_val[k]  = 32'(-quo[k]);
        end
      end else begin
        if (sf.lane[k].ovf || quo[k] > SAT_POS) begin
          lane_err[k] = 1'b1;
          res_val[k]  = SAT_POS;
        end else begin
          res_val[k]  = quo[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x       <= res_val[0];
      res.out_y       <= res_val[1];
      res.out_z       <= res_val[2];
      res.range_error <= lane_err[0] | lane_err[1] | lane_err[2];
    end
  end

endmodule

// ===== tb/homogeneous_point_transform_tb.sv =====
// Testbench for the homogeneous point transform: random and directed commands, scoreboard check.
module homogeneous_point_transform_tb;
  import hpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  homogeneous_point_transform i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // Matrix mirror, row-major Q16.16, and results still owed by the block.
  logic [31:0] mirror_matrix [16];
  cmd_t        pending_cmds [$];
  res_t        owed_points [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          done_sending;

  // Transfer seen at the last rising edge, so the driver can move on.
  logic cmd_ready_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void load_identity_mirror();
    for (int i = 0; i < 16; i++)
      mirror_matrix[i] = ((i % 4) == (i / 4)) ? Q_ONE : Q_ZERO;
  endfunction

  // Row dot product: exact products, each floored by 16 bits, plus translation.
  function automatic logic signed [63:0] row_sum(int r, logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [31:0] pz);
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [31:0] pt [3];
    pt[0] = px; pt[1] = py; pt[2] = pz;
    acc = 64'(signed'(mirror_matrix[r*4+3]));
    for (int c = 0; c < 3; c++) begin
      prod = 64'(signed'(mirror_matrix[r*4+c])) * 64'(pt[c]);
      acc += prod >>> 16;
    end
    return acc;
  endfunction

  // Saturating (num << 16) / den on magnitudes, truncated toward zero.
  function automatic logic [31:0] sat_quotient(logic signed [63:0] num,
                                               logic signed [63:0] den,
                                               inout logic err);
    logic        nneg;
    logic        dneg;
    logic [63:0] nm;
    logic [63:0] dm;
    logic [63:0] q;
    nneg = num < 0;
    dneg = den < 0;
    nm = nneg ? -num : num;
    dm = dneg ? -den : den;
    if (dm == 0) begin
      err = 1'b1;
      if (nm == 0) return Q_ZERO;
      return nneg ? SAT_NEG : SAT_POS;
    end
    q = (nm << 16) / dm;
    if (nneg != dneg) begin
      if (q > 64'h8000_0000) begin
        err = 1'b1;
        return SAT_NEG;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      err = 1'b1;
      return SAT_POS;
    end
    return q[31:0];
  endfunction

  // Apply one accepted command to the mirror; queue a point if one is due.
  function automatic void apply_command(cmd_t c);
    logic signed [63:0] w;
    res_t               p;
    logic               err;
    case (c.command)
      CMD_WRITE: begin
        mirror_matrix[c.entry_index] = c.entry_value;
      end
      CMD_IDENTITY: begin
        load_identity_mirror();
      end
      CMD_TRANSFORM: begin
        err = 1'b0;
        w = row_sum(3, c.in_x, c.in_y, c.in_z);
        p.out_x = sat_quotient(row_sum(0, c.in_x, c.in_y, c.in_z), w, err);
        p.out_y = sat_quotient(row_sum(1, c.in_x, c.in_y, c.in_z), w, err);
        p.out_z = sat_quotient(row_sum(2, c.in_x, c.in_y, c.in_z), w, err);
        p.range_error = err;
        owed_points.push_back(p);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: advance on the falling edge; hold payload until the transfer.
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_ready_seen) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd       <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
    res_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk) begin
    cmd_ready_seen <= 1'b0;
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        apply_command(cmd);
        cmd_ready_seen <= 1'b1;
      end
      if (res_valid && res_ready) begin
        if (owed_points.size() == 0) begin
          report_mismatch("unexpected point", res.out_x, 32'h0);
        end else begin
          res_t want;
          want = owed_points.pop_front();
          if (res.out_x !== want.out_x) report_mismatch("out_x", res.out_x, want.out_x);
          if (res.out_y !== want.out_y) report_mismatch("out_y", res.out_y, want.out_y);
          if (res.out_z !== want.out_z) report_mismatch("out_z", res.out_z, want.out_z);
          if (res.range_error !== want.range_error)
            report_mismatch("range_error", 32'(res.range_error), 32'(want.range_error));
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t make_cmd(cmd_code_t op, logic [3:0] idx, logic [31:0] v,
                                    logic [31:0] x, logic [31:0] y, logic [31:0] z);
    cmd_t c;
    c.command = op; c.entry_index = idx; c.entry_value = v;
    c.in_x = x; c.in_y = y; c.in_z = z;
    return c;
  endfunction

  // Matrix entries and points mix full-range, small (within +/-2.0) and extreme words.
  task automatic queue_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30)
        pending_cmds.push_back(make_cmd(CMD_WRITE, 4'($urandom), rand_word(),
                                        $urandom, $urandom, $urandom));
      else if (r < 34)
        pending_cmds.push_back(make_cmd(CMD_IDENTITY, 4'($urandom), $urandom,
                                        $urandom, $urandom, $urandom));
      else if (r < 37)
        pending_cmds.push_back(make_cmd(CMD_UNUSED, 4'($urandom), $urandom,
                                        $urandom, $urandom, $urandom));
      else
        pending_cmds.push_back(make_cmd(CMD_TRANSFORM, 4'($urandom), $urandom,
                                        rand_word(), rand_word(), rand_word()));
    end
  endtask

  // Drain: wait for the queues to empty, then past the pipeline depth.
  task automatic drain();
    wait (pending_cmds.size() == 0 && !cmd_valid);
    wait (owed_points.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct  = 26;
    recv_idle_pct  = 67;
    rst            = 1'b1;
    load_identity_mirror();
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: identity pass-through, extremes, zero w, saturation, unused command.
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, Q_ONE, SAT_NEG, SAT_POS));
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_UNUSED, 4'hF, SAT_NEG, 32'd1, 32'd2, 32'd3));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 4'd15, Q_ZERO, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, Q_ONE, 32'hFFFF_0000, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 4'd15, 32'h0000_0001, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, SAT_POS, SAT_NEG, Q_ONE));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 4'd15, 32'hFFFF_0000, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 4'd0, SAT_NEG, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 4'd5, SAT_POS, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 4'd3, SAT_POS, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, SAT_NEG, SAT_NEG, SAT_NEG));
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, SAT_POS, SAT_POS, SAT_POS));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 4'd12, Q_ONE, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, Q_ONE, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_IDENTITY, '0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_TRANSFORM, '0, '0, 32'h1234_5678, 32'd1,
                                    32'hFFFF_FFFF));
    queue_random(140);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 26;
    queue_random(130);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(130);
    drain();

    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hpt_pkg.sv
rtl/core/hpt_divider.sv
rtl/core/homogeneous_point_transform.sv
tb/homogeneous_point_transform_tb.sv
